[hdl/assert_macros.svh]
// Assertion helpers for the translation table
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Concurrent check, gated by the active-low reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check that also holds while reset is applied
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`endif

[hdl/mrkt_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrkt_pkg
// Shared types and codes of the memory region key translation table.
// ----------------------------------------------------------------------------
package mrkt_pkg;

  localparam int unsigned TableDepth = 1024;

  typedef enum logic [1:0] {
    OP_TRANSLATE = 2'd0,
    OP_REGISTER  = 2'd1,
    OP_REMOVE    = 2'd2,
    OP_UNKNOWN   = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_BAD_OP    = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [31:0] key;
    logic [63:0] vbase;
    logic [63:0] pbase;
    logic [31:0] len;
  } entry_t;

endpackage

[hdl/memory_region_key_translation_table_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// memory_region_key_translation_table_top
// Ordered region table with key/range translation, append and compacting remove.
// ----------------------------------------------------------------------------
// Channel   Direction  Transfer rule
// command   in         start_i high while busy_o low
// result    out        done_o high for one cycle, cannot be stalled
//
// Commands do not overlap: busy_o stays high until the result is shown. Register
// and unknown opcodes go straight to S_DONE. Translate reads the table in order,
// one table read per cycle through the single read port, and stops at the first
// hit. Remove scans the same way, then moves each later entry one place down,
// reading it in S_SHIFT_RD and writing it in S_SHIFT_WR.
// Reset clears the count, last size and control; table contents need none.
// The receiver cannot stall: the result is shown for one cycle only.
// ----------------------------------------------------------------------------
module memory_region_key_translation_table_top #(
  parameter int unsigned TABLE_DEPTH = mrkt_pkg::TableDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  opcode_i,
  input  logic [31:0] region_key_i,
  input  logic [63:0] virt_addr_i,
  input  logic [63:0] phys_addr_in_i,
  input  logic [31:0] region_length_i,
  output logic        done_o,
  output logic [63:0] phys_addr_out_o,
  output logic [31:0] region_size_o,
  output logic [1:0]  status_o
);

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] DepthC = CW'(TABLE_DEPTH);

  // Table memory: one write, one registered read port
  mrkt_pkg::entry_t mem [TABLE_DEPTH];
  mrkt_pkg::entry_t rd_q;
  logic [AW-1:0]    rd_addr;
  logic             we;
  logic [AW-1:0]    wr_addr;
  mrkt_pkg::entry_t wr_data;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  mrkt_pkg::state_e st_q, st_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] idx_q, idx_d;   // entry being issued to the read port
  logic          pend_q, pend_d; // rd_q holds entry idx_q-1
  logic [31:0]   size_q, size_d;
  logic [1:0]    op_q, op_d;
  logic [31:0]   key_q, key_d;
  logic [63:0]   va_q, va_d, res_q, res_d;
  logic [1:0]    sts_q, sts_d;

  logic [63:0] end_a, off_a;
  logic        tr_hit, rm_hit;
  assign end_a  = rd_q.vbase + {32'd0, rd_q.len};
  assign off_a  = rd_q.pbase + (va_q - rd_q.vbase);
  assign tr_hit = (rd_q.key == key_q) && (va_q >= rd_q.vbase) && (va_q <= end_a);
  assign rm_hit = (rd_q.key == key_q) && (rd_q.vbase == va_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= mrkt_pkg::S_IDLE;
      cnt_q  <= '0;
      idx_q  <= '0;
      pend_q <= 1'b0;
      size_q <= '0;
    end else begin
      st_q   <= st_d;
      cnt_q  <= cnt_d;
      idx_q  <= idx_d;
      pend_q <= pend_d;
      size_q <= size_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q  <= op_d;
    key_q <= key_d;
    va_q  <= va_d;
    res_q <= res_d;
    sts_q <= sts_d;
  end

  always_comb begin
    st_d = st_q; cnt_d = cnt_q; idx_d = idx_q; pend_d = 1'b0; size_d = size_q;
    op_d = op_q; key_d = key_q; va_d = va_q;
    res_d = res_q; sts_d = sts_q;
    rd_addr = idx_q[AW-1:0];
    we = 1'b0; wr_addr = idx_q[AW-1:0]; wr_data = rd_q;
    unique case (st_q)
      mrkt_pkg::S_IDLE: begin
        if (start_i) begin
          op_d = opcode_i; key_d = region_key_i; va_d = virt_addr_i;
          idx_d = '0;
          unique case (mrkt_pkg::opcode_e'(opcode_i))
            mrkt_pkg::OP_TRANSLATE, mrkt_pkg::OP_REMOVE: begin
              res_d = (opcode_i == mrkt_pkg::OP_REMOVE) ? phys_addr_in_i : virt_addr_i;
              sts_d = mrkt_pkg::ST_NOT_FOUND;
              st_d  = mrkt_pkg::S_SCAN;
            end
            mrkt_pkg::OP_REGISTER: begin
              res_d = phys_addr_in_i;
              if (cnt_q >= DepthC) begin
                sts_d = mrkt_pkg::ST_FULL;
              end else begin
                we      = 1'b1;
                wr_addr = cnt_q[AW-1:0];
                wr_data = '{key: region_key_i, vbase: virt_addr_i,
                            pbase: phys_addr_in_i, len: region_length_i};
                cnt_d   = cnt_q + 1'b1;
                sts_d   = mrkt_pkg::ST_OK;
              end
              st_d = mrkt_pkg::S_DONE;
            end
            default: begin
              res_d = virt_addr_i;
              sts_d = mrkt_pkg::ST_BAD_OP;
              st_d  = mrkt_pkg::S_DONE;
            end
          endcase
        end
      end
      mrkt_pkg::S_SCAN: begin
        // issue one read per cycle, check the entry read last cycle
        priority if (pend_q && op_q == mrkt_pkg::OP_TRANSLATE && tr_hit) begin
          res_d  = off_a;
          size_d = rd_q.len;
          sts_d  = mrkt_pkg::ST_OK;
          st_d   = mrkt_pkg::S_DONE;
        end else if (pend_q && op_q == mrkt_pkg::OP_REMOVE && rm_hit) begin
          // idx_q is the first later entry; idx_q-1 is the hole
          sts_d = mrkt_pkg::ST_OK;
          cnt_d = cnt_q - 1'b1;
          st_d  = (idx_q < cnt_q) ? mrkt_pkg::S_SHIFT_RD : mrkt_pkg::S_DONE;
        end else if (idx_q < cnt_q) begin
          pend_d = 1'b1;
          idx_d  = idx_q + 1'b1;
        end else begin
          st_d = mrkt_pkg::S_DONE;
        end
      end
      mrkt_pkg::S_SHIFT_RD: begin
        // read entry idx_q; it lands in rd_q next cycle
        st_d = mrkt_pkg::S_SHIFT_WR;
      end
      mrkt_pkg::S_SHIFT_WR: begin
        // drop it one place down
        we      = 1'b1;
        wr_addr = AW'(idx_q - 1'b1);
        idx_d   = idx_q + 1'b1;
        st_d    = (idx_q + 1'b1 <= cnt_q) ? mrkt_pkg::S_SHIFT_RD : mrkt_pkg::S_DONE;
      end
      mrkt_pkg::S_DONE: st_d = mrkt_pkg::S_IDLE;
      default: st_d = mrkt_pkg::S_IDLE;
    endcase
  end

  assign busy_o          = (st_q != mrkt_pkg::S_IDLE);
  assign done_o          = (st_q == mrkt_pkg::S_DONE);
  assign phys_addr_out_o = res_q;
  assign region_size_o   = size_q;
  assign status_o        = sts_q;

  `include "assert_macros.svh"
  `ASSERT_ALWAYS(a_count_bound, clk_i, (!rst_ni || cnt_q <= DepthC), "entry count above depth")
  `ASSERT_CLK(a_done_one, clk_i, rst_ni, done_o |=> !done_o, "done held two cycles")
  `ASSERT_CLK(a_size_hit, clk_i, rst_ni,
    (!$stable(size_q)) |-> (done_o && status_o == mrkt_pkg::ST_OK), "size moved without hit")
  `ASSERT_CLK(a_cnt_step, clk_i, rst_ni,
    (cnt_q != $past(cnt_q)) |-> (busy_o || done_o || $past(busy_o)), "count moved while idle")

endmodule

[tb/tb_memory_region_key_translation_table_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_memory_region_key_translation_table_top
// Self-checking bench for the region key translation table.
// ----------------------------------------------------------------------------
// A queue of commands is filled up front: a short directed set (empty table,
// extreme fields, inclusive ends, wrapping region, duplicate keys, compaction,
// unknown opcode) and a random mix that keeps the table small and aims most
// translates and removes at registered regions. A clocked driver feeds the
// queue with random idle cycles and predicts each accepted command; a clocked
// monitor compares every strobed result with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_memory_region_key_translation_table_top;

  typedef struct {
    bit                drain;   // marker: hold off until every result has come back
    mrkt_pkg::opcode_e op;
    logic [31:0]       key;
    logic [63:0]       va;
    logic [63:0]       pa;
    logic [31:0]       len;
  } cmd_t;

  typedef struct {
    logic [63:0]       pa;
    logic [31:0]       size;
    mrkt_pkg::status_e st;
  } result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  logic [1:0]  opcode_i = '0;
  logic [31:0] region_key_i = '0;
  logic [63:0] virt_addr_i = '0;
  logic [63:0] phys_addr_in_i = '0;
  logic [31:0] region_length_i = '0;
  logic        done_o;
  logic [63:0] phys_addr_out_o;
  logic [31:0] region_size_o;
  logic [1:0]  status_o;

  memory_region_key_translation_table_top u_top (
    .clk_i, .rst_ni, .start_i, .busy_o, .opcode_i, .region_key_i, .virt_addr_i,
    .phys_addr_in_i, .region_length_i, .done_o, .phys_addr_out_o,
    .region_size_o, .status_o
  );

  cmd_t    cmd_pending[$];
  result_t result_expected[$];
  cmd_t    cmd_active;
  int      n_total;
  int      n_sent;
  int      n_errors;

  // Shadow copy of the region table
  logic [31:0] sh_key[mrkt_pkg::TableDepth];
  logic [63:0] sh_vbase[mrkt_pkg::TableDepth];
  logic [63:0] sh_pbase[mrkt_pkg::TableDepth];
  logic [31:0] sh_len[mrkt_pkg::TableDepth];
  int          sh_count;
  logic [31:0] sh_last_size;

  // Generator's view of what it registered, used to aim hits
  logic [31:0] gen_key[$];
  logic [63:0] gen_vb[$];
  logic [31:0] gen_len[$];

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Apply one accepted command to the shadow table and queue its result.
  task automatic apply_region_cmd(input cmd_t c);
    result_t r;
    logic [63:0] end_addr;
    r.pa = c.va;
    r.st = mrkt_pkg::ST_BAD_OP;
    case (c.op)
      mrkt_pkg::OP_TRANSLATE: begin
        r.st = mrkt_pkg::ST_NOT_FOUND;
        for (int i = 0; i < sh_count; i++) begin
          end_addr = sh_vbase[i] + {32'd0, sh_len[i]};
          if (sh_key[i] == c.key && c.va >= sh_vbase[i] && c.va <= end_addr) begin
            r.pa = sh_pbase[i] + (c.va - sh_vbase[i]);
            sh_last_size = sh_len[i];
            r.st = mrkt_pkg::ST_OK;
            break;
          end
        end
      end
      mrkt_pkg::OP_REGISTER: begin
        r.pa = c.pa;
        if (sh_count >= mrkt_pkg::TableDepth) begin
          r.st = mrkt_pkg::ST_FULL;
        end else begin
          sh_key[sh_count] = c.key;
          sh_vbase[sh_count] = c.va;
          sh_pbase[sh_count] = c.pa;
          sh_len[sh_count] = c.len;
          sh_count++;
          r.st = mrkt_pkg::ST_OK;
        end
      end
      mrkt_pkg::OP_REMOVE: begin
        r.pa = c.pa;
        r.st = mrkt_pkg::ST_NOT_FOUND;
        for (int i = 0; i < sh_count; i++) begin
          if (sh_key[i] == c.key && sh_vbase[i] == c.va) begin
            for (int j = i; j < sh_count - 1; j++) begin
              sh_key[j] = sh_key[j + 1];
              sh_vbase[j] = sh_vbase[j + 1];
              sh_pbase[j] = sh_pbase[j + 1];
              sh_len[j] = sh_len[j + 1];
            end
            sh_count--;
            r.st = mrkt_pkg::ST_OK;
            break;
          end
        end
      end
      default: ;
    endcase
    r.size = sh_last_size;
    result_expected.push_back(r);
  endtask

  task automatic push_cmd(input mrkt_pkg::opcode_e op, input logic [31:0] key,
                          input logic [63:0] va, input logic [63:0] pa,
                          input logic [31:0] len);
    cmd_t c;
    c.drain = 1'b0;
    c.op = op;
    c.key = key;
    c.va = va;
    c.pa = pa;
    c.len = len;
    cmd_pending.push_back(c);
    if (op == mrkt_pkg::OP_REGISTER) begin
      gen_key.push_back(key);
      gen_vb.push_back(va);
      gen_len.push_back(len);
    end
  endtask

  task automatic push_drain();
    cmd_t c;
    c.drain = 1'b1;
    c.op = mrkt_pkg::OP_TRANSLATE;
    c.key = '0;
    c.va = '0;
    c.pa = '0;
    c.len = '0;
    cmd_pending.push_back(c);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic push_random_cmd(input int keep_max);
    int          pick;
    int          k;
    logic [63:0] va;
    logic [31:0] len;
    pick = $urandom_range(99);
    // table large: turn translates into removes
    if (gen_key.size() > keep_max && pick < 45) pick = 80;
    if (pick < 45) begin
      if (gen_key.size() != 0 && $urandom_range(99) < 80) begin
        k = $urandom_range(gen_key.size() - 1);
        case ($urandom_range(5))
          0: va = gen_vb[k];
          1: va = gen_vb[k] + gen_len[k];
          2: va = gen_vb[k] + gen_len[k] + 1;
          3: va = gen_vb[k] - 1;
          default: va = gen_vb[k] + $urandom_range(gen_len[k]);
        endcase
        push_cmd(mrkt_pkg::OP_TRANSLATE, gen_key[k], va, rand64(), $urandom);
      end else begin
        push_cmd(mrkt_pkg::OP_TRANSLATE, $urandom_range(3), rand64(), rand64(), $urandom);
      end
    end else if (pick < 70) begin
      // mostly short regions, sometimes a full-width length
      len = ($urandom_range(9) == 0) ? $urandom : $urandom_range(4096);
      va = ($urandom_range(9) == 0) ? ~64'd0 - $urandom_range(2048) : rand64();
      push_cmd(mrkt_pkg::OP_REGISTER,
               ($urandom_range(3) == 0) ? $urandom : $urandom_range(3),
               va, rand64(), len);
    end else if (pick < 92) begin
      if (gen_key.size() != 0 && $urandom_range(99) < 80) begin
        k = $urandom_range(gen_key.size() - 1);
        push_cmd(mrkt_pkg::OP_REMOVE, gen_key[k], gen_vb[k], rand64(), $urandom);
        gen_key.delete(k);
        gen_vb.delete(k);
        gen_len.delete(k);
      end else begin
        push_cmd(mrkt_pkg::OP_REMOVE, $urandom_range(3), rand64(), rand64(), $urandom);
      end
    end else begin
      push_cmd(mrkt_pkg::OP_UNKNOWN, $urandom, rand64(), rand64(), $urandom);
    end
  endtask

  // Stimulus
  initial begin
    sh_count = 0;
    sh_last_size = '0;
    n_sent = 0;
    n_errors = 0;
    // empty table and unknown opcode
    push_cmd(mrkt_pkg::OP_UNKNOWN, 32'hFFFF_FFFF, ~64'd0, 64'd0, 32'hFFFF_FFFF);
    push_cmd(mrkt_pkg::OP_TRANSLATE, 32'd0, 64'd0, ~64'd0, 32'd0);
    push_cmd(mrkt_pkg::OP_REMOVE, 32'd0, 64'd0, ~64'd0, 32'd0);
    // extreme fields, both inclusive ends
    push_cmd(mrkt_pkg::OP_REGISTER, 32'hFFFF_FFFF, 64'd0, ~64'd0, 32'hFFFF_FFFF);
    push_cmd(mrkt_pkg::OP_TRANSLATE, 32'hFFFF_FFFF, 64'd0, 64'd0, 32'd0);
    push_cmd(mrkt_pkg::OP_TRANSLATE, 32'hFFFF_FFFF, 64'hFFFF_FFFF, 64'd0, 32'd0);
    push_cmd(mrkt_pkg::OP_TRANSLATE, 32'hFFFF_FFFF, 64'h1_0000_0000, 64'd0, 32'd0);
    push_cmd(mrkt_pkg::OP_TRANSLATE, 32'hFFFF_FFFE, 64'd5, 64'd0, 32'd0);
    // region whose end wraps past the top of the address space
    push_cmd(mrkt_pkg::OP_REGISTER, 32'd7, 64'hFFFF_FFFF_FFFF_FF00, 64'h1000, 32'h200);
    push_cmd(mrkt_pkg::OP_TRANSLATE, 32'd7, 64'hFFFF_FFFF_FFFF_FF80, 64'd0, 32'd0);
    push_cmd(mrkt_pkg::OP_TRANSLATE, 32'd7, 64'h50, 64'd0, 32'd0);
    // zero-length region and duplicate keys, earliest wins
    push_cmd(mrkt_pkg::OP_REGISTER, 32'd0, 64'h100, 64'd0, 32'd0);
    push_cmd(mrkt_pkg::OP_TRANSLATE, 32'd0, 64'h100, 64'd0, 32'd0);
    push_cmd(mrkt_pkg::OP_TRANSLATE, 32'd0, 64'h101, 64'd0, 32'd0);
    push_cmd(mrkt_pkg::OP_REGISTER, 32'd0, 64'h100, 64'h5000, 32'h40);
    push_cmd(mrkt_pkg::OP_TRANSLATE, 32'd0, 64'h100, 64'd0, 32'd0);
    push_cmd(mrkt_pkg::OP_TRANSLATE, 32'd0, 64'h120, 64'd0, 32'd0);
    // key matches but base differs, then removal with compaction
    push_cmd(mrkt_pkg::OP_REMOVE, 32'd0, 64'h101, 64'hAAAA, 32'd0);
    push_cmd(mrkt_pkg::OP_REMOVE, 32'd0, 64'h100, 64'hBBBB, 32'd0);
    push_cmd(mrkt_pkg::OP_TRANSLATE, 32'd0, 64'h120, 64'd0, 32'd0);
    push_cmd(mrkt_pkg::OP_REMOVE, 32'hFFFF_FFFF, 64'd0, ~64'd0, 32'd0);
    push_cmd(mrkt_pkg::OP_TRANSLATE, 32'd7, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0, 32'd0);
    push_drain();
    gen_key.delete();
    gen_vb.delete();
    gen_len.delete();
    for (int i = 0; i < 558; i++) begin
      push_random_cmd(40);
      if (i % 150 == 149) push_drain();
    end
    n_total = cmd_pending.size();
  end

  // Driver: hold the command until it transfers, then fetch the next.
  always @(posedge clk_i or negedge rst_ni) begin
    int  idle_pct;
    bit  take;
    if (!rst_ni) begin
      start_i <= 1'b0;
    end else begin
      take = 1'b0;
      if (start_i && !busy_o) begin
        apply_region_cmd(cmd_active);
        n_sent++;
      end
      if (!start_i || !busy_o) begin
        if (cmd_pending.size() != 0 && cmd_pending[0].drain) begin
          // pause the feed until every outstanding result is back
          if (result_expected.size() == 0 && !start_i) void'(cmd_pending.pop_front());
        end else if (cmd_pending.size() != 0) begin
          idle_pct = (n_sent < n_total / 3) ? 38 : (n_sent < 2 * n_total / 3) ? 59 : 0;
          take = ($urandom_range(99) >= idle_pct);
        end
        if (take) begin
          cmd_active = cmd_pending.pop_front();
          opcode_i <= cmd_active.op;
          region_key_i <= cmd_active.key;
          virt_addr_i <= cmd_active.va;
          phys_addr_in_i <= cmd_active.pa;
          region_length_i <= cmd_active.len;
        end
        start_i <= take;
      end
    end
  end

  // Monitor: every strobed result must match the oldest prediction.
  always @(posedge clk_i) begin
    result_t r;
    if (rst_ni && done_o) begin
      if (result_expected.size() == 0) begin
        $display("%0t: unexpected result pa=%h size=%h status=%0d", $time,
                 phys_addr_out_o, region_size_o, status_o);
        n_errors++;
      end else begin
        r = result_expected.pop_front();
        if (phys_addr_out_o !== r.pa) begin
          $display("%0t: phys_addr_out expected %h actual %h", $time, r.pa, phys_addr_out_o);
          n_errors++;
        end
        if (region_size_o !== r.size) begin
          $display("%0t: region_size expected %h actual %h", $time, r.size, region_size_o);
          n_errors++;
        end
        if (status_o !== r.st) begin
          $display("%0t: status expected %0d actual %0d", $time, r.st, status_o);
          n_errors++;
        end
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (n_total > 0 && cmd_pending.size() == 0 && !start_i);
    wait (result_expected.size() == 0);
    // allow a full compaction pass for any stray strobe
    repeat (3200) @(posedge clk_i);
    if (n_errors == 0 && result_expected.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #200ms;
    $display("Verification failed");
    $finish;
  end

endmodule
